### src/gals_pkg.sv
// Shared types, codes and constants for the grid agent local step block.
// Used by every module under src; has no dependencies of its own.
package gals_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int OUT_COORD_W     = 16;
    localparam int VIEW_SIDE       = 5;
    localparam int CELL_BITS       = 2;
    localparam int VIEW_CELLS      = VIEW_SIDE * VIEW_SIDE;
    localparam int VIEW_W          = VIEW_CELLS * CELL_BITS;
    localparam int NUM_OFFSETS     = 9;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int PERIOD_W        = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic KIND_MOVE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [CELL_BITS-1:0] CELL_FREE  = 2'd0;
    localparam logic [CELL_BITS-1:0] CELL_AGENT = 2'd1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEST_X  = 3'd0,
        CFG_DEST_Y  = 3'd1,
        CFG_START_X = 3'd2,
        CFG_START_Y = 3'd3,
        CFG_PERIOD  = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        RULE_NONE   = 2'd0,
        RULE_DIRECT = 2'd1,
        RULE_DETOUR = 2'd2
    } move_rule_t;

    typedef struct packed {
        logic              kind;
        logic [VIEW_W-1:0] view;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_COORD_W-1:0] pos_x;
        logic signed [OUT_COORD_W-1:0] pos_y;
        logic                          moved;
        logic [1:0]                    move_rule;
        logic                          priority_northwest;
    } out_item_t;

    // Classified item: which of the nine offsets are allowed under either priority half.
    typedef struct packed {
        logic                   kind;
        logic [NUM_OFFSETS-1:0] allowed_nw;
        logic [NUM_OFFSETS-1:0] allowed_se;
    } queue_entry_t;

    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_write_t;

endpackage

### src/grid_agent_local_step.sv
// Top level of the grid agent local step block: front classifier, queue, back end.
// Depends on gals_pkg, gals_front, gals_queue and gals_back.
//
//   Channel  Signals                             Direction  Moves per transaction
//   item     item_valid, item_stall, item        in         kind and 5x5 view
//   result   result_valid, result_stall, result  out        position, moved, rule, priority
//   cfg      cfg_valid, cfg_ready, index/data    in         one register write
//
// One item per cycle sustained when neither result_stall nor a remainder pass holds the
// back end; a result is registered in the cycle after its item leaves the queue, so an
// accepted item passes through a queue entry and then the result register.
// A write to the period register starts a remainder pass over the tick counter;
// the back end executes no queued item during it, while items keep filling the queue.
// rst_n is asynchronous and active low; position, destination and counter clear,
// the period returns to 2 and the north-west half has priority.
// result_stall holds the result register; the two-entry queue then fills and
// item_stall rises only when both entries are taken.
module grid_agent_local_step
#(
    parameter int COORD_WIDTH = gals_pkg::COORD_WIDTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  gals_pkg::in_item_t                  item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output gals_pkg::out_item_t                 result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gals_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gals_pkg::CFG_DATA_W-1:0]     cfg_data
);

    gals_pkg::queue_entry_t front_entry;
    gals_pkg::queue_entry_t head_entry;
    gals_pkg::cfg_write_t   cfg;
    logic                   queue_full;
    logic                   head_valid;
    logic                   pop;
    logic                   push;

    // The front end is state free, so an item is classified on the cycle it arrives
    // and written straight into the queue.
    assign push       = item_valid && !queue_full;
    assign item_stall = queue_full;

    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    gals_front u_front
    (
        .item  (item),
        .entry (front_entry)
    );

    gals_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (front_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    gals_back
    #(
        .COORD_WIDTH (COORD_WIDTH)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .pop          (pop),
        .cfg          (cfg),
        .cfg_ready    (cfg_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

### src/gals_front.sv
// Front end: classifies one incoming item into per-offset step permissions.
// Depends on gals_pkg for the item and queue entry types.
module gals_front
(
    input  gals_pkg::in_item_t     item,
    output gals_pkg::queue_entry_t entry
);

    // Cells whose row or column lies within one of the target cell.
    function automatic logic [gals_pkg::VIEW_CELLS-1:0] cross_mask(input int tr, input int tc);
        logic [gals_pkg::VIEW_CELLS-1:0] m;
        int dr;
        int dc;
        m = '0;
        for (int r = 0; r < gals_pkg::VIEW_SIDE; r++)
        begin
            for (int c = 0; c < gals_pkg::VIEW_SIDE; c++)
            begin
                dr = (r > tr) ? r - tr : tr - r;
                dc = (c > tc) ? c - tc : tc - c;
                m[r * gals_pkg::VIEW_SIDE + c] = (dr <= 1) || (dc <= 1);
            end
        end
        return m;
    endfunction

    // North-west half: rows 0..1 and the two cells left of center. South-east mirrors it.
    function automatic logic [gals_pkg::VIEW_CELLS-1:0] half_mask(input logic northwest);
        logic [gals_pkg::VIEW_CELLS-1:0] m;
        m = '0;
        for (int r = 0; r < gals_pkg::VIEW_SIDE; r++)
        begin
            for (int c = 0; c < gals_pkg::VIEW_SIDE; c++)
            begin
                if (northwest)
                begin
                    m[r * gals_pkg::VIEW_SIDE + c] = (r < 2) || ((r == 2) && (c < 2));
                end
                else
                begin
                    m[r * gals_pkg::VIEW_SIDE + c] = (r > 2) || ((r == 2) && (c > 2));
                end
            end
        end
        return m;
    endfunction

    localparam logic [gals_pkg::VIEW_CELLS-1:0] NW_MASK = half_mask(1'b1);
    localparam logic [gals_pkg::VIEW_CELLS-1:0] SE_MASK = half_mask(1'b0);

    logic [gals_pkg::VIEW_CELLS-1:0] agent;

    always_comb
    begin
        for (int i = 0; i < gals_pkg::VIEW_CELLS; i++)
        begin
            agent[i] = (item.view[i * gals_pkg::CELL_BITS +: gals_pkg::CELL_BITS]
                        == gals_pkg::CELL_AGENT);
        end
    end

    always_comb
    begin
        logic                            free;
        logic [gals_pkg::VIEW_CELLS-1:0] near;
        entry.kind = item.kind;
        for (int a = 0; a < 3; a++)
        begin
            for (int b = 0; b < 3; b++)
            begin
                free = (item.view[((a + 1) * gals_pkg::VIEW_SIDE + (b + 1))
                                  * gals_pkg::CELL_BITS +: gals_pkg::CELL_BITS]
                        == gals_pkg::CELL_FREE);
                near = agent & cross_mask(a + 1, b + 1);
                entry.allowed_nw[a * 3 + b] = free && !(|(near & NW_MASK));
                entry.allowed_se[a * 3 + b] = free && !(|(near & SE_MASK));
            end
        end
    end

endmodule

### src/gals_queue.sv
// Short FIFO between the front end and the back end of the agent block.
// Depends on gals_pkg for the queue entry type and depth.
module gals_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  gals_pkg::queue_entry_t push_entry,
    output logic                   full,
    input  logic                   pop,
    output logic                   head_valid,
    output gals_pkg::queue_entry_t head_entry
);

    localparam int DEPTH = gals_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gals_pkg::queue_entry_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### src/gals_back.sv
// Back end: holds position, priority half, tick counter and configuration,
// executes classified items and registers one result per item. Depends on gals_pkg.
module gals_back
#(
    parameter int COORD_WIDTH = gals_pkg::COORD_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  gals_pkg::queue_entry_t head_entry,
    output logic                   pop,
    input  gals_pkg::cfg_write_t   cfg,
    output logic                   cfg_ready,
    output logic                   result_valid,
    input  logic                   result_stall,
    output gals_pkg::out_item_t    result
);

    localparam int CW        = COORD_WIDTH;
    localparam int DW        = ((CW > gals_pkg::CFG_DATA_W) ? CW : gals_pkg::CFG_DATA_W) + 2;
    localparam int PW        = gals_pkg::PERIOD_W;
    localparam int RED_CNT_W = $clog2(PW + 1);

    logic signed [CW-1:0] pos_x_reg, pos_x_next;
    logic signed [CW-1:0] pos_y_reg, pos_y_next;
    logic signed [gals_pkg::CFG_DATA_W-1:0] dest_x_reg, dest_x_next;
    logic signed [gals_pkg::CFG_DATA_W-1:0] dest_y_reg, dest_y_next;
    logic [PW-1:0] period_reg, period_next;
    logic [PW-1:0] tick_count_reg, tick_count_next;
    logic          nw_reg, nw_next;
    logic [PW-1:0] red_bits_reg, red_bits_next;
    logic [PW-1:0] red_rem_reg, red_rem_next;
    logic [RED_CNT_W-1:0] red_left_reg, red_left_next;
    gals_pkg::out_item_t result_reg, result_next;
    logic                result_valid_reg, result_valid_next;

    logic          red_busy;
    logic [PW-1:0] pe;

    logic signed [DW-1:0] dx, dy, adx, ady;
    logic signed [DW:0]   sum_pp, sum_pm;
    logic [gals_pkg::NUM_OFFSETS-1:0] allowed, gain;
    logic [3:0] k_dir, k_det, k_sel;
    logic       detour_found, direct_ok;
    gals_pkg::move_rule_t rule;
    logic [1:0] a_code, b_code;

    // Offset index k = 3*(a+1) + (b+1): returns the row step code (0: -1, 1: 0, 2: +1).
    function automatic logic [1:0] row_code(input logic [3:0] k);
        unique case (k)
            4'd0, 4'd1, 4'd2: return 2'd0;
            4'd3, 4'd4, 4'd5: return 2'd1;
            4'd6, 4'd7, 4'd8: return 2'd2;
            default:          return 2'd1;
        endcase
    endfunction

    function automatic logic [1:0] col_code(input logic [3:0] k);
        unique case (k)
            4'd0, 4'd3, 4'd6: return 2'd0;
            4'd1, 4'd4, 4'd7: return 2'd1;
            4'd2, 4'd5, 4'd8: return 2'd2;
            default:          return 2'd1;
        endcase
    endfunction

    function automatic logic [CW-1:0] step_of(input logic [1:0] code);
        return {{(CW - 1){code == 2'd0}}, code != 2'd1};
    endfunction

    assign red_busy  = (red_left_reg != '0);
    assign pe        = (period_reg == '0) ? PW'(1) : period_reg;
    assign cfg_ready = 1'b1;
    assign pop       = head_valid && !red_busy && (!result_valid_reg || !result_stall);

    assign dx     = DW'(dest_x_reg) - DW'(pos_x_reg);
    assign dy     = DW'(dest_y_reg) - DW'(pos_y_reg);
    assign adx    = dx[DW-1] ? -dx : dx;
    assign ady    = dy[DW-1] ? -dy : dy;
    assign sum_pp = (DW + 1)'(dx) + (DW + 1)'(dy);
    assign sum_pm = (DW + 1)'(dx) - (DW + 1)'(dy);

    assign allowed = nw_reg ? head_entry.allowed_nw : head_entry.allowed_se;

    // Direct step: larger axis, or diagonal on a tie.
    always_comb
    begin
        logic [1:0] ra;
        logic [1:0] rb;
        ra = (adx < ady) ? 2'd1 : ((dx > 0) ? 2'd2 : 2'd0);
        rb = (adx > ady) ? 2'd1 : ((dy > 0) ? 2'd2 : 2'd0);
        k_dir = 4'(ra) * 4'd3 + 4'(rb);
    end

    assign direct_ok = allowed[k_dir];

    // Offsets that strictly lower the squared distance. A diagonal gains when
    // the dot product with the distance vector reaches two.
    always_comb
    begin
        gain[0] = sum_pp < -1;
        gain[1] = dx < 0;
        gain[2] = sum_pm < -1;
        gain[3] = dy < 0;
        gain[4] = 1'b0;
        gain[5] = dy > 0;
        gain[6] = sum_pm > 1;
        gain[7] = dx > 0;
        gain[8] = sum_pp > 1;
    end

    always_comb
    begin
        detour_found = 1'b0;
        k_det        = '0;
        for (int i = 0; i < gals_pkg::NUM_OFFSETS; i++)
        begin
            if (!detour_found && gain[i] && allowed[i])
            begin
                detour_found = 1'b1;
                k_det        = 4'(i);
            end
        end
    end

    always_comb
    begin
        if (direct_ok)
        begin
            rule  = gals_pkg::RULE_DIRECT;
            k_sel = k_dir;
        end
        else if (detour_found)
        begin
            rule  = gals_pkg::RULE_DETOUR;
            k_sel = k_det;
        end
        else
        begin
            rule  = gals_pkg::RULE_NONE;
            k_sel = 4'd4;
        end
        a_code = row_code(k_sel);
        b_code = col_code(k_sel);
    end

    always_comb
    begin
        logic [PW:0]   trial;
        logic [DW-1:0] ext_x;
        logic [DW-1:0] ext_y;
        logic [DW-1:0] ext_cfg;
        pos_x_next        = pos_x_reg;
        pos_y_next        = pos_y_reg;
        dest_x_next       = dest_x_reg;
        dest_y_next       = dest_y_reg;
        period_next       = period_reg;
        tick_count_next   = tick_count_reg;
        nw_next           = nw_reg;
        red_bits_next     = red_bits_reg;
        red_rem_next      = red_rem_reg;
        red_left_next     = red_left_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        trial             = '0;

        if (pop)
        begin
            result_next.moved     = 1'b0;
            result_next.move_rule = gals_pkg::RULE_NONE;
            if (head_entry.kind == gals_pkg::KIND_TICK)
            begin
                if (tick_count_reg == pe - 1'b1)
                begin
                    tick_count_next = '0;
                    nw_next         = !nw_reg;
                end
                else
                begin
                    tick_count_next = tick_count_reg + 1'b1;
                end
            end
            else if (rule != gals_pkg::RULE_NONE)
            begin
                pos_x_next            = pos_x_reg + step_of(a_code);
                pos_y_next            = pos_y_reg + step_of(b_code);
                result_next.moved     = 1'b1;
                result_next.move_rule = rule;
            end
            result_valid_next = 1'b1;
        end

        ext_x = {{(DW - CW){pos_x_next[CW-1]}}, pos_x_next};
        ext_y = {{(DW - CW){pos_y_next[CW-1]}}, pos_y_next};
        if (pop)
        begin
            result_next.pos_x              = ext_x[gals_pkg::OUT_COORD_W-1:0];
            result_next.pos_y              = ext_y[gals_pkg::OUT_COORD_W-1:0];
            result_next.priority_northwest = nw_next;
        end

        // Restoring remainder pass, one bit a cycle, after a period write.
        if (red_busy)
        begin
            trial = {red_rem_reg, red_bits_reg[PW-1]};
            if (trial >= {1'b0, pe})
            begin
                trial = trial - {1'b0, pe};
            end
            red_rem_next  = trial[PW-1:0];
            red_bits_next = red_bits_reg << 1;
            red_left_next = red_left_reg - 1'b1;
            if (red_left_reg == RED_CNT_W'(1))
            begin
                tick_count_next = trial[PW-1:0];
            end
        end

        ext_cfg = {{(DW - gals_pkg::CFG_DATA_W){cfg.data[gals_pkg::CFG_DATA_W-1]}}, cfg.data};
        if (cfg.valid)
        begin
            unique case (gals_pkg::cfg_index_t'(cfg.index))
                gals_pkg::CFG_DEST_X:  dest_x_next = cfg.data;
                gals_pkg::CFG_DEST_Y:  dest_y_next = cfg.data;
                gals_pkg::CFG_START_X: pos_x_next  = ext_cfg[CW-1:0];
                gals_pkg::CFG_START_Y: pos_y_next  = ext_cfg[CW-1:0];
                gals_pkg::CFG_PERIOD:
                begin
                    period_next   = cfg.data[PW-1:0];
                    red_bits_next = tick_count_reg;
                    red_rem_next  = '0;
                    red_left_next = RED_CNT_W'(PW);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg        <= '0;
            pos_y_reg        <= '0;
            dest_x_reg       <= '0;
            dest_y_reg       <= '0;
            period_reg       <= PW'(2);
            tick_count_reg   <= '0;
            nw_reg           <= 1'b1;
            red_left_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            pos_x_reg        <= pos_x_next;
            pos_y_reg        <= pos_y_next;
            dest_x_reg       <= dest_x_next;
            dest_y_reg       <= dest_y_next;
            period_reg       <= period_next;
            tick_count_reg   <= tick_count_next;
            nw_reg           <= nw_next;
            red_left_reg     <= red_left_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        red_bits_reg <= red_bits_next;
        red_rem_reg  <= red_rem_next;
        result_reg   <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Outside a remainder pass the counter always lies below the effective period.
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !red_busy |-> (tick_count_reg < pe))
        else $error("tick counter at or above period");

    // A tick is never executed while the counter is being reduced.
    a_no_tick_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && head_entry.kind == gals_pkg::KIND_TICK && red_busy) |-> !pop)
        else $error("tick executed during remainder pass");

    // A taken step really changes the position; a refused step or a tick leaves it alone and still gives a result.
    a_step_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !cfg.valid && head_entry.kind == gals_pkg::KIND_MOVE
         && rule != gals_pkg::RULE_NONE)
        |=> ((pos_x_reg != $past(pos_x_reg)) || (pos_y_reg != $past(pos_y_reg))))
        else $error("step taken without position change");

    a_hold_still: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !cfg.valid && (head_entry.kind == gals_pkg::KIND_TICK
         || rule == gals_pkg::RULE_NONE))
        |=> ($stable(pos_x_reg) && $stable(pos_y_reg) && result_valid_reg))
        else $error("position changed without a step");

endmodule
